// File: src/pwsf_pkg.sv
package pwsf_pkg;

    // Operation codes carried by the operation field
    typedef enum logic [1:0] {
        OP_SPECIAL = 2'd0,
        OP_STORE   = 2'd1,
        OP_READ    = 2'd2,
        OP_COLL    = 2'd3
    } t_op;

    // Merge modes, XOR beats OR
    typedef enum logic [1:0] {
        MRG_COPY = 2'd0,
        MRG_OR   = 2'd1,
        MRG_XOR  = 2'd2
    } t_merge;

    // Back end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_EXEC  = 2'd1,
        BK_SPILL = 2'd2
    } t_bk_state;

    // Configuration register indexes
    localparam logic REG_WRITE_MODE = 1'b0;
    localparam logic REG_EXPAND     = 1'b1;

    // write_mode bit positions
    localparam int MODE_EXPAND_BIT = 3;
    localparam int MODE_OR_BIT     = 4;
    localparam int MODE_XOR_BIT    = 5;
    localparam int MODE_FLIP_BIT   = 6;

    localparam logic [7:0] COLL_SET  = 8'hff;
    localparam logic [7:0] COLL_KEEP = 8'h0f;

    localparam int QUEUE_DEPTH = 2;

    // Classified command passed from front to back
    typedef struct packed {
        t_op         op;
        logic [13:0] addr;
        logic [7:0]  data;   // shifted own-byte data, or raw store data
        logic [7:0]  spill;  // pixels spilled into the neighbor byte
        logic [7:0]  mask;   // own-byte pixels covered by the data
        logic        flip;   // neighbor is address-1 when set
        t_merge      merge;
    } t_cmd;

    // Queue status seen by the back end and the top level
    typedef struct packed {
        logic       empty;
        logic       full;
    } t_q_status;

endpackage

// File: src/pwsf_front.sv
module pwsf_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [1:0]       i_operation,
    input  logic [13:0]      i_address,
    input  logic [7:0]       i_write_byte,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [7:0]       i_cfg_data,
    output pwsf_pkg::t_cmd   o_cmd
);

    logic [7:0] r_write_mode;
    logic [7:0] r_expand_colours;
    logic       r_low_nibble;

    logic [3:0]  nib;
    logic [7:0]  expanded;
    logic [7:0]  base;
    logic [7:0]  flipped;
    logic [7:0]  pix;
    logic [2:0]  shamt;
    logic [15:0] shifted;
    logic        flip;
    logic        expand;
    pwsf_pkg::t_op op;

    assign op     = pwsf_pkg::t_op'(i_operation);
    assign flip   = r_write_mode[pwsf_pkg::MODE_FLIP_BIT];
    assign expand = r_write_mode[pwsf_pkg::MODE_EXPAND_BIT];
    assign shamt  = {r_write_mode[1:0], 1'b0};

    // Nibble expansion: nibble bit 3 lands in pixel 0
    always_comb begin
        nib = r_low_nibble ? i_write_byte[3:0] : i_write_byte[7:4];
        for (int p = 0; p < 4; p++) begin
            expanded[7-2*p -: 2] = nib[3-p] ? r_expand_colours[3:2] : r_expand_colours[1:0];
        end
        base = expand ? expanded : i_write_byte;
        for (int p = 0; p < 4; p++) begin
            flipped[7-2*p -: 2] = base[2*p +: 2];
        end
        pix = flip ? flipped : base;
    end

    // Shift with spill: right into address+1, left into address-1 when flipped
    always_comb begin
        if (flip) begin
            shifted = {8'h00, pix} << shamt;
        end else begin
            shifted = {pix, 8'h00} >> shamt;
        end
    end

    // Classified command
    always_comb begin
        o_cmd.op   = op;
        o_cmd.addr = i_address;
        o_cmd.flip = flip;
        if (op == pwsf_pkg::OP_SPECIAL) begin
            o_cmd.data  = flip ? shifted[7:0]  : shifted[15:8];
            o_cmd.spill = flip ? shifted[15:8] : shifted[7:0];
            o_cmd.mask  = flip ? (8'hff << shamt) : (8'hff >> shamt);
        end else begin
            o_cmd.data  = i_write_byte;
            o_cmd.spill = 8'h00;
            o_cmd.mask  = 8'hff;
        end
        if (r_write_mode[pwsf_pkg::MODE_XOR_BIT]) begin
            o_cmd.merge = pwsf_pkg::MRG_XOR;
        end else if (r_write_mode[pwsf_pkg::MODE_OR_BIT]) begin
            o_cmd.merge = pwsf_pkg::MRG_OR;
        end else begin
            o_cmd.merge = pwsf_pkg::MRG_COPY;
        end
    end

    // Config registers and nibble toggle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_mode     <= 8'h00;
            r_expand_colours <= 8'h00;
            r_low_nibble     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == pwsf_pkg::REG_WRITE_MODE) begin
                    r_write_mode <= i_cfg_data;
                end else begin
                    r_expand_colours <= i_cfg_data;
                end
            end
            if (i_push && op == pwsf_pkg::OP_SPECIAL && expand) begin
                r_low_nibble <= ~r_low_nibble;
            end
        end
    end

endmodule

// File: src/pwsf_queue.sv
module pwsf_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  pwsf_pkg::t_cmd        i_cmd,
    input  logic                  i_pop,
    output pwsf_pkg::t_cmd        o_cmd,
    output pwsf_pkg::t_q_status   o_status
);

    localparam int QW = $clog2(pwsf_pkg::QUEUE_DEPTH);

    pwsf_pkg::t_cmd r_slot [pwsf_pkg::QUEUE_DEPTH];
    logic [QW-1:0]  r_wr_ptr;
    logic [QW-1:0]  r_rd_ptr;
    logic [QW:0]    r_count;

    assign o_cmd           = r_slot[r_rd_ptr];
    assign o_status.empty  = (r_count == '0);
    assign o_status.full   = (r_count == (QW+1)'(pwsf_pkg::QUEUE_DEPTH));

    // Slot storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: src/pwsf_back.sv
module pwsf_back #(
    parameter int MEMORY_BYTES = 16384
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pwsf_pkg::t_cmd        i_cmd,
    input  pwsf_pkg::t_q_status   i_q_status,
    output logic                  o_pop,
    output logic                  o_valid,
    output logic [7:0]            o_read_byte,
    output pwsf_pkg::t_bk_state   o_state
);

    localparam int AW = $clog2(MEMORY_BYTES);
    localparam int XW = ((AW > 14) ? AW : 14) + 2;
    localparam logic [XW-1:0] LIMIT = XW'(MEMORY_BYTES);

    logic [7:0] mem [MEMORY_BYTES];

    pwsf_pkg::t_bk_state r_state, n_state;
    pwsf_pkg::t_cmd      r_cmd;
    logic [AW-1:0]       r_own_idx;
    logic [AW-1:0]       r_nb_idx;
    logic                r_own_ok;
    logic                r_nb_ok;
    logic [7:0]          r_rd_own;
    logic [7:0]          r_rd_nb;
    logic [7:0]          r_nb_wdata, n_nb_wdata;
    logic [7:0]          r_coll, n_coll;
    logic                r_valid, n_valid;
    logic [7:0]          r_rdata, n_rdata;

    logic [XW-1:0] own_x;
    logic [XW-1:0] nb_x;
    logic [7:0]    own_old;
    logic [7:0]    nb_old;
    logic [7:0]    own_new;
    logic [7:0]    nb_new;
    logic          hit;
    logic          mem_we;
    logic [AW-1:0] mem_widx;
    logic [7:0]    mem_wdata;

    assign o_valid     = r_valid;
    assign o_read_byte = r_rdata;
    assign o_state     = r_state;

    // Addresses of the queue head; neighbor below zero wraps out of range
    assign own_x = XW'(i_cmd.addr);
    assign nb_x  = i_cmd.flip ? (own_x - 1'b1) : (own_x + 1'b1);

    // Old contents, zero outside memory
    assign own_old = r_own_ok ? r_rd_own : 8'h00;
    assign nb_old  = r_nb_ok  ? r_rd_nb  : 8'h00;

    // Merge and collision check
    always_comb begin
        case (r_cmd.merge)
            pwsf_pkg::MRG_XOR: begin
                own_new = r_cmd.data ^ own_old;
                nb_new  = r_cmd.spill ^ nb_old;
            end
            pwsf_pkg::MRG_OR: begin
                own_new = r_cmd.data | own_old;
                nb_new  = r_cmd.spill | nb_old;
            end
            default: begin
                own_new = r_cmd.data | (~r_cmd.mask & own_old);
                nb_new  = r_cmd.spill | (r_cmd.mask & nb_old);
            end
        endcase
        hit = (|(r_cmd.mask & own_old)) || (|(~r_cmd.mask & nb_old));
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pwsf_pkg::BK_IDLE: begin
                if (!i_q_status.empty) begin
                    n_state = pwsf_pkg::BK_EXEC;
                end
            end
            pwsf_pkg::BK_EXEC: begin
                if (r_cmd.op == pwsf_pkg::OP_SPECIAL) begin
                    n_state = pwsf_pkg::BK_SPILL;
                end else begin
                    n_state = pwsf_pkg::BK_IDLE;
                end
            end
            pwsf_pkg::BK_SPILL: begin
                n_state = pwsf_pkg::BK_IDLE;
            end
            default: begin
                n_state = pwsf_pkg::BK_IDLE;
            end
        endcase
    end

    // Outputs: memory writes, collision register, result
    always_comb begin
        o_pop      = 1'b0;
        mem_we     = 1'b0;
        mem_widx   = r_own_idx;
        mem_wdata  = r_cmd.data;
        n_nb_wdata = r_nb_wdata;
        n_coll     = r_coll;
        n_valid    = 1'b0;
        n_rdata    = 8'h00;
        case (r_state)
            pwsf_pkg::BK_IDLE: begin
                o_pop = !i_q_status.empty;
            end
            pwsf_pkg::BK_EXEC: begin
                case (r_cmd.op)
                    pwsf_pkg::OP_SPECIAL: begin
                        mem_we     = r_own_ok;
                        mem_wdata  = own_new;
                        n_nb_wdata = nb_new;
                        if (r_cmd.merge != pwsf_pkg::MRG_COPY) begin
                            n_coll = hit ? pwsf_pkg::COLL_SET : (r_coll & pwsf_pkg::COLL_KEEP);
                        end
                    end
                    pwsf_pkg::OP_STORE: begin
                        mem_we  = r_own_ok;
                        n_valid = 1'b1;
                    end
                    pwsf_pkg::OP_READ: begin
                        n_valid = 1'b1;
                        n_rdata = own_old;
                    end
                    default: begin
                        n_valid = 1'b1;
                        n_rdata = r_coll;
                        n_coll  = 8'h00;
                    end
                endcase
            end
            pwsf_pkg::BK_SPILL: begin
                mem_we    = r_nb_ok;
                mem_widx  = r_nb_idx;
                mem_wdata = r_nb_wdata;
                n_valid   = 1'b1;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    // Frame store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_widx] <= mem_wdata;
        end
        if (o_pop) begin
            r_rd_own <= mem[own_x[AW-1:0]];
            r_rd_nb  <= mem[nb_x[AW-1:0]];
        end
    end

    // Command capture on pop
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd     <= i_cmd;
            r_own_idx <= own_x[AW-1:0];
            r_nb_idx  <= nb_x[AW-1:0];
            r_own_ok  <= (own_x < LIMIT);
            r_nb_ok   <= (nb_x < LIMIT);
        end
        r_nb_wdata <= n_nb_wdata;
        r_rdata    <= n_rdata;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pwsf_pkg::BK_IDLE;
            r_coll  <= 8'h00;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_coll  <= n_coll;
            r_valid <= n_valid;
        end
    end

endmodule

// File: src/pixel_write_shift_flip_logic_unit.sv
// Channel   Direction  Signals                                      Transaction
// command   in         start, busy, i_operation, i_address,         start & !busy
//                      i_write_byte
// result    out        o_valid, o_read_byte                         o_valid, one cycle
// config    in         i_cfg_we, i_cfg_idx, i_cfg_data              i_cfg_we
//
// A command waits in a two-entry queue; the back end pops it in IDLE, then runs
// EXEC for a store, read or collision read, and EXEC then SPILL for a special
// write, set by the single write port of the frame store (own byte, then
// neighbor byte). The result is registered from the last back end step and
// shows for one cycle only. busy is high while the queue is full. Reset is
// synchronous, active low; it clears the queue, collision register, nibble
// select and config registers. The frame store has no reset.
module pixel_write_shift_flip_logic_unit #(
    parameter int MEMORY_BYTES = 16384
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [13:0] i_address,
    input  logic [7:0]  i_write_byte,
    output logic        o_valid,
    output logic [7:0]  o_read_byte,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);

    pwsf_pkg::t_cmd        front_cmd;
    pwsf_pkg::t_cmd        head_cmd;
    pwsf_pkg::t_q_status   q_status;
    pwsf_pkg::t_bk_state   bk_state;
    logic                  push;
    logic                  pop;

    assign busy = q_status.full;
    assign push = start && !busy;

    pwsf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_operation  (i_operation),
        .i_address    (i_address),
        .i_write_byte (i_write_byte),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_cmd        (front_cmd)
    );

    pwsf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (front_cmd),
        .i_pop    (pop),
        .o_cmd    (head_cmd),
        .o_status (q_status)
    );

    pwsf_back #(
        .MEMORY_BYTES (MEMORY_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .o_read_byte (o_read_byte),
        .o_state     (bk_state)
    );

    // Results never come in adjacent cycles
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe in adjacent cycles");

    // An accepted command is held in the queue on the next cycle
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> !q_status.empty)
        else $error("accepted command missing from queue");

    // A result strobe follows a back end step out of EXEC or SPILL
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> bk_state == pwsf_pkg::BK_IDLE)
        else $error("result strobe while back end busy");

endmodule
